### src/lzsd_pkg.sv
`default_nettype none
package lzsd_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = 12;
    localparam int CNT_W      = HIST_AW + 1;
    localparam int MAX_MATCH  = 18;
    localparam int MATCH_BIAS = 3;
    localparam int FLAG_COUNT = 8;

    localparam logic [HIST_AW-1:0] START_POS  = HIST_AW'(HIST_DEPTH - MAX_MATCH);
    localparam logic [7:0]         FILL_RESET = 8'd32;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_UNIT = 2'd1,
        PH_PAIR = 2'd2
    } t_phase;

    typedef struct packed {
        logic               restart;
        logic [7:0]         fill;
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } t_hist_req;

endpackage
`default_nettype wire

### src/lzsd_in_if.sv
`default_nettype none
interface lzsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_start;

    modport source (output valid, output in_byte, output stream_start, input ready);
    modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface
`default_nettype wire

### src/lzsd_out_if.sv
`default_nettype none
interface lzsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;

    modport source (output valid, output out_byte, output last_of_item, input ready);
    modport sink   (input valid, input out_byte, input last_of_item, output ready);
endinterface
`default_nettype wire

### src/lzsd_history.sv
`default_nettype none
module lzsd_history (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lzsd_pkg::t_hist_req  i_req,
    output logic [7:0]                o_rd_byte
);

    logic [7:0]                 mem [lzsd_pkg::HIST_DEPTH];
    logic [7:0]                 r_rd_data;
    logic [7:0]                 r_fwd_data;
    logic                       r_fwd_hit;
    logic                       r_rd_valid;
    logic [lzsd_pkg::CNT_W-1:0] r_count;
    logic [7:0]                 r_fill;
    logic [lzsd_pkg::HIST_AW-1:0] rel_addr;
    logic                       entry_written;

    assign rel_addr      = i_req.rd_addr - lzsd_pkg::START_POS;
    assign entry_written = {1'b0, rel_addr} < r_count;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= mem[i_req.rd_addr];
            r_fwd_data <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_fill     <= lzsd_pkg::FILL_RESET;
            r_fwd_hit  <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.restart) begin
                r_count <= '0;
                r_fill  <= i_req.fill;
            end else if (i_req.wr_en && !r_count[lzsd_pkg::CNT_W-1]) begin
                r_count <= r_count + 1'b1;
            end
            if (i_req.rd_en) begin
                r_fwd_hit  <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
                r_rd_valid <= entry_written;
            end
        end
    end

    // forwarded byte wins, then a written entry, else the stream fill value
    assign o_rd_byte = r_fwd_hit ? r_fwd_data : (r_rd_valid ? r_rd_data : r_fill);

endmodule
`default_nettype wire

### src/lzsd_ctrl.sv
`default_nettype none
module lzsd_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [7:0]           i_cfg_wdata,
    lzsd_in_if.sink                   i_in,
    lzsd_out_if.source                o_out,
    output lzsd_pkg::t_hist_req       o_hist_req,
    input  wire logic [7:0]           i_rd_byte
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_COPY = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    lzsd_pkg::t_phase             r_phase, n_phase;
    logic [lzsd_pkg::HIST_AW-1:0] r_wp, n_wp;
    logic [lzsd_pkg::HIST_AW-1:0] r_src, n_src;
    logic [7:0]                   r_flags, n_flags;
    logic [3:0]                   r_flags_left, n_flags_left;
    logic [7:0]                   r_off_lo, n_off_lo;
    logic [4:0]                   r_left, n_left;
    logic [7:0]                   r_fill_cfg;
    logic                         r_out_valid, n_out_valid;
    logic [7:0]                   r_out_byte, n_out_byte;
    logic                         r_out_last, n_out_last;

    logic                         out_free;
    logic                         acc;
    lzsd_pkg::t_phase             eff_phase;
    logic [7:0]                   nu_flags;
    logic [3:0]                   nu_left;
    lzsd_pkg::t_phase             nu_phase;
    logic [lzsd_pkg::HIST_AW-1:0] pair_off;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign acc        = i_in.valid && i_in.ready;
    assign eff_phase  = i_in.stream_start ? lzsd_pkg::PH_FLAG : r_phase;

    assign nu_flags = r_flags >> 1;
    assign nu_left  = (r_flags_left != 4'd0) ? r_flags_left - 4'd1 : 4'd0;
    assign nu_phase = (nu_left == 4'd0) ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_UNIT;
    assign pair_off = {i_in.in_byte[7:4], r_off_lo};

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.last_of_item = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_wp         = r_wp;
        n_src        = r_src;
        n_flags      = r_flags;
        n_flags_left = r_flags_left;
        n_off_lo     = r_off_lo;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        o_hist_req         = '0;
        o_hist_req.fill    = r_fill_cfg;
        o_hist_req.rd_addr = r_src;
        o_hist_req.wr_addr = r_wp;
        o_hist_req.wr_data = i_in.in_byte;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_in.stream_start) begin
                        o_hist_req.restart = 1'b1;
                        n_wp = lzsd_pkg::START_POS;
                    end
                    unique case (eff_phase)
                        lzsd_pkg::PH_UNIT: begin
                            if (r_flags[0]) begin
                                o_hist_req.wr_en = 1'b1;
                                n_wp         = r_wp + 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_byte   = i_in.in_byte;
                                n_out_last   = 1'b1;
                                n_flags      = nu_flags;
                                n_flags_left = nu_left;
                                n_phase      = nu_phase;
                            end else begin
                                n_off_lo = i_in.in_byte;
                                n_phase  = lzsd_pkg::PH_PAIR;
                            end
                        end
                        lzsd_pkg::PH_PAIR: begin
                            o_hist_req.rd_en   = 1'b1;
                            o_hist_req.rd_addr = pair_off;
                            n_src        = pair_off + 1'b1;
                            n_left       = 5'({1'b0, i_in.in_byte[3:0]})
                                           + 5'(lzsd_pkg::MATCH_BIAS);
                            n_flags      = nu_flags;
                            n_flags_left = nu_left;
                            n_phase      = nu_phase;
                            n_state      = S_COPY;
                        end
                        default: begin
                            n_flags      = i_in.in_byte;
                            n_flags_left = 4'(lzsd_pkg::FLAG_COUNT);
                            n_phase      = lzsd_pkg::PH_UNIT;
                        end
                    endcase
                end
            end
            S_COPY: begin
                if (out_free) begin
                    o_hist_req.wr_en   = 1'b1;
                    o_hist_req.wr_data = i_rd_byte;
                    n_wp        = r_wp + 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = i_rd_byte;
                    n_out_last  = (r_left == 5'd1);
                    n_left      = r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        n_state = S_IDLE;
                    end else begin
                        o_hist_req.rd_en = 1'b1;
                        n_src = r_src + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= lzsd_pkg::PH_FLAG;
            r_wp         <= lzsd_pkg::START_POS;
            r_flags      <= '0;
            r_flags_left <= '0;
            r_left       <= '0;
            r_fill_cfg   <= lzsd_pkg::FILL_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_wp         <= n_wp;
            r_flags      <= n_flags;
            r_flags_left <= n_flags_left;
            r_left       <= n_left;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_fill_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_off_lo   <= n_off_lo;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule
`default_nettype wire

### src/lzss_stream_decoder.sv
// Flag and first pair bytes: no output. Literal: output registered on acceptance.
// Pair: 3 to 18 output bytes, one per cycle while the output is not stalled; the next byte
// is taken after the last copy byte. The history has a single read port.
// History reads are registered; a byte written in the read cycle is forwarded.
// Reset (i_rst_n low, synchronous): empty output, fill value 32, history reads as 32
// until written, write position 4078; no clearing pass, a fill count tracks written entries.
`default_nettype none
module lzss_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    lzsd_in_if.sink         i_in,
    lzsd_out_if.source      o_out
);

    lzsd_pkg::t_hist_req hist_req;
    logic [7:0]          rd_byte;

    lzsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_hist_req  (hist_req),
        .i_rd_byte   (rd_byte)
    );

    lzsd_history u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (hist_req),
        .o_rd_byte (rd_byte)
    );

endmodule
`default_nettype wire

### src/lzsd_checker.sv
`default_nettype none
module lzsd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_stream_start,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last))
        else $error("output transaction changed while stalled");

    a_no_take_mid_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken while a copy is unfinished");

    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_stream_start |=> !i_out_valid)
        else $error("output after a stream start byte");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind lzss_stream_decoder lzsd_checker u_lzsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_stream_start (i_in.stream_start),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_byte        (o_out.out_byte),
    .i_out_last        (o_out.last_of_item)
);
`default_nettype wire
